[design/bdns_pkg.sv]
// ----------------------------------------------------------------------------
// bdns_pkg
// Shared constants, types and the sequencer state for the near-depth selector.
// ----------------------------------------------------------------------------
package bdns_pkg;

   localparam int MAX_SAMPLES   = 16384;
   localparam int DEPTH_BITS    = 16;
   localparam int COORD_BITS    = 12;

   localparam int BOX_BITS      = COORD_BITS + 1;
   localparam int ADDR_BITS     = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int BIT_IDX_BITS  = $clog2(DEPTH_BITS);
   localparam int RES_BITS      = DEPTH_BITS + 1;
   localparam int CSR_DATA_BITS = (DEPTH_BITS > BOX_BITS) ? DEPTH_BITS : BOX_BITS;
   localparam int CSR_IDX_BITS  = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_LEFT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_TOP    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_DEPTH  = 3'd4;

   localparam logic [DEPTH_BITS-1:0] MIN_DEPTH_RESET = DEPTH_BITS'(100);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_STEP
   } state_type;

   // box limits and depth floor
   typedef struct packed {
      logic signed [BOX_BITS-1:0] left;
      logic signed [BOX_BITS-1:0] top;
      logic signed [BOX_BITS-1:0] right;
      logic signed [BOX_BITS-1:0] bottom;
      logic [DEPTH_BITS-1:0]      min_depth;
   } box_cfg_type;

   // one pixel after the box test
   typedef struct packed {
      logic                  accept;
      logic                  keep;
      logic                  last;
      logic [DEPTH_BITS-1:0] depth;
   } sample_type;

   // sequencer strobes
   typedef struct packed {
      logic store;
      logic ovf_set;
      logic init;
      logic issue;
      logic step;
      logic finish;
   } ctl_type;

endpackage

[design/bdns_filter.sv]
// ----------------------------------------------------------------------------
// bdns_filter
// Box and depth-floor test on each incoming pixel.
// ----------------------------------------------------------------------------
module bdns_filter import bdns_pkg::*; (
   input  logic                  accept,
   input  logic [DEPTH_BITS-1:0] depth_mm,
   input  logic [COORD_BITS-1:0] pixel_col,
   input  logic [COORD_BITS-1:0] pixel_row,
   input  logic                  frame_last,
   input  box_cfg_type           cfg,
   output sample_type            sample
);

   logic signed [BOX_BITS-1:0] col_s;
   logic signed [BOX_BITS-1:0] row_s;
   logic                       in_box;

   // coordinates are unsigned, so a zero top bit makes them safe to compare signed
   assign col_s  = $signed({1'b0, pixel_col});
   assign row_s  = $signed({1'b0, pixel_row});
   assign in_box = (col_s >= cfg.left) && (col_s < cfg.right) &&
                   (row_s >= cfg.top)  && (row_s < cfg.bottom);

   always_comb begin
      sample.accept = accept;
      sample.keep   = in_box && (depth_mm > cfg.min_depth);
      sample.last   = frame_last;
      sample.depth  = depth_mm;
   end

endmodule

[design/bdns_select.sv]
// ----------------------------------------------------------------------------
// bdns_select
// Sample store and order-statistic search: a bit-at-a-time search on the
// value, one counting pass over the store per bit, sharing a single compare.
// ----------------------------------------------------------------------------
module bdns_select import bdns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sample_type          sample,
   output logic                busy,
   output logic                rsp_valid,
   output logic [RES_BITS-1:0] rsp_depth_half_mm,
   output logic                rsp_found,
   output logic                rsp_overflowed
);

   logic [DEPTH_BITS-1:0] store_mem [MAX_SAMPLES];

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [CNT_BITS-1:0]     count_ff;
   logic [CNT_BITS-1:0]     k_ff;
   logic [2:0]              m5_ff;
   logic                    ovf_ff;
   logic [CNT_BITS-1:0]     idx_ff;
   logic                    rdv_ff;
   logic [DEPTH_BITS-1:0]   rd_data_ff;
   logic [CNT_BITS-1:0]     cnt_lt_ff;
   logic [DEPTH_BITS-1:0]   prefix_ff;
   logic [BIT_IDX_BITS-1:0] bit_ff;
   logic [CNT_BITS-1:0]     target_ff;
   logic                    two_ff;
   logic                    second_ff;
   logic [DEPTH_BITS-1:0]   first_ff;
   logic                    rsp_valid_ff;
   logic [RES_BITS-1:0]     rsp_depth_ff;
   logic                    rsp_found_ff;
   logic                    rsp_ovf_ff;

   logic                  room;
   logic                  scan_done;
   logic                  last_pass;
   logic [DEPTH_BITS-1:0] thr;
   logic                  take;
   logic [DEPTH_BITS-1:0] new_prefix;
   logic [CNT_BITS-1:0]   j_sel;
   logic [RES_BITS-1:0]   result;

   assign room      = count_ff < CNT_BITS'(MAX_SAMPLES);
   assign scan_done = (idx_ff == count_ff) && !rdv_ff;
   assign last_pass = (bit_ff == '0) && (!two_ff || second_ff);
   assign thr       = prefix_ff | (DEPTH_BITS'(1) << bit_ff);
   // fewer than target+1 samples below thr: answer is at least thr
   assign take       = cnt_lt_ff <= target_ff;
   assign new_prefix = take ? thr : prefix_ff;

   always_comb begin
      if (k_ff == '0) begin
         j_sel = '0;
      end else if (k_ff[0]) begin
         j_sel = k_ff >> 1;
      end else begin
         j_sel = (k_ff >> 1) - CNT_BITS'(1);
      end
   end

   always_comb begin
      if (two_ff) begin
         result = RES_BITS'(first_ff) + RES_BITS'(new_prefix);
      end else begin
         result = {new_prefix, 1'b0};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample.accept && sample.last) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = last_pass ? ST_IDLE : ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer strobes
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.store   = sample.accept && sample.keep && room;
            ctl.ovf_set = sample.accept && sample.keep && !room;
         end
         ST_PREP: begin
            ctl.init   = 1'b1;
            ctl.finish = count_ff == '0;
         end
         ST_SCAN: begin
            ctl.issue = idx_ff < count_ff;
         end
         ST_STEP: begin
            ctl.step   = 1'b1;
            ctl.finish = last_pass;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.store) store_mem[count_ff[ADDR_BITS-1:0]] <= sample.depth;
      if (ctl.issue) rd_data_ff <= store_mem[idx_ff[ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         m5_ff        <= '0;
         ovf_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= ctl.issue;
         rsp_valid_ff <= ctl.finish;
         if (ctl.store) begin
            count_ff <= count_ff + CNT_BITS'(1);
            // k = count / 5 kept as the samples arrive
            if (m5_ff == 3'd4) begin
               m5_ff <= '0;
               k_ff  <= k_ff + CNT_BITS'(1);
            end else begin
               m5_ff <= m5_ff + 3'd1;
            end
         end
         if (ctl.ovf_set) ovf_ff <= 1'b1;
         if (ctl.finish) begin
            count_ff <= '0;
            k_ff     <= '0;
            m5_ff    <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         prefix_ff <= '0;
         bit_ff    <= BIT_IDX_BITS'(DEPTH_BITS - 1);
         idx_ff    <= '0;
         cnt_lt_ff <= '0;
         second_ff <= 1'b0;
         target_ff <= j_sel;
         two_ff    <= (k_ff != '0) && !k_ff[0];
      end
      if (ctl.issue) idx_ff <= idx_ff + CNT_BITS'(1);
      if (rdv_ff && (rd_data_ff < thr)) cnt_lt_ff <= cnt_lt_ff + CNT_BITS'(1);
      if (ctl.step) begin
         idx_ff    <= '0;
         cnt_lt_ff <= '0;
         if (bit_ff == '0) begin
            // first value done, search again for the next rank
            first_ff  <= new_prefix;
            prefix_ff <= '0;
            bit_ff    <= BIT_IDX_BITS'(DEPTH_BITS - 1);
            second_ff <= 1'b1;
            target_ff <= target_ff + CNT_BITS'(1);
         end else begin
            prefix_ff <= new_prefix;
            bit_ff    <= bit_ff - BIT_IDX_BITS'(1);
         end
      end
      if (ctl.finish) begin
         rsp_depth_ff <= ctl.step ? result : '0;
         rsp_found_ff <= ctl.step;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth_half_mm = rsp_depth_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

endmodule

[design/box_near_depth_select_core.sv]
// ----------------------------------------------------------------------------
// box_near_depth_select_core
// Near-depth estimate over a box of a streamed depth frame.
// ----------------------------------------------------------------------------
// Pixels that are not last in the frame: one item per cycle while busy is low,
// and they leave busy low. Last pixel: with n samples kept, the prep state
//   issues the result strobe when n = 0, else one counting pass over the single-port
//   sample store per bit, two searches if floor(n/5) is even and non-zero.
// Results cannot be stalled. Synchronous reset clears count, flags and the
// registers (min depth to 100); the sample store is not cleared.
module box_near_depth_select_core import bdns_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [DEPTH_BITS-1:0]    req_depth_mm,
   input  logic [COORD_BITS-1:0]    req_pixel_col,
   input  logic [COORD_BITS-1:0]    req_pixel_row,
   input  logic                     req_frame_last,
   output logic                     rsp_valid,
   output logic [RES_BITS-1:0]      rsp_depth_half_mm,
   output logic                     rsp_found,
   output logic                     rsp_overflowed,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   box_cfg_type cfg_ff;
   sample_type  sample;
   logic        sel_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left      <= '0;
         cfg_ff.top       <= '0;
         cfg_ff.right     <= '0;
         cfg_ff.bottom    <= '0;
         cfg_ff.min_depth <= MIN_DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BOX_LEFT:   cfg_ff.left      <= $signed(csr_data[BOX_BITS-1:0]);
            REG_BOX_TOP:    cfg_ff.top       <= $signed(csr_data[BOX_BITS-1:0]);
            REG_BOX_RIGHT:  cfg_ff.right     <= $signed(csr_data[BOX_BITS-1:0]);
            REG_BOX_BOTTOM: cfg_ff.bottom    <= $signed(csr_data[BOX_BITS-1:0]);
            REG_MIN_DEPTH:  cfg_ff.min_depth <= csr_data[DEPTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   bdns_filter u_filter (
      .accept     (start && !sel_busy),
      .depth_mm   (req_depth_mm),
      .pixel_col  (req_pixel_col),
      .pixel_row  (req_pixel_row),
      .frame_last (req_frame_last),
      .cfg        (cfg_ff),
      .sample     (sample)
   );

   bdns_select u_select (
      .clock             (clock),
      .reset             (reset),
      .sample            (sample),
      .busy              (sel_busy),
      .rsp_valid         (rsp_valid),
      .rsp_depth_half_mm (rsp_depth_half_mm),
      .rsp_found         (rsp_found),
      .rsp_overflowed    (rsp_overflowed)
   );

   assign busy = sel_busy;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for box_near_depth_select_core. Streams pixel frames
// under a series of box and depth-floor settings, predicts the near-depth
// median of every frame and compares each result strobe field by field.
// ----------------------------------------------------------------------------
module tb;
   import bdns_pkg::*;

   localparam int     CLK_HALF     = 6;
   localparam longint LIMIT_CYCLES = 4_000_000;
   localparam int     RAND_ITEMS   = 1150;
   localparam int     PHASE_ITEMS  = 90;

   // predicted near-depth results, oldest first
   class depth_scoreboard;
      typedef struct {
         logic [RES_BITS-1:0] depth_half_mm;
         logic                found;
         logic                overflowed;
      } near_result_type;

      logic signed [BOX_BITS-1:0] left, top, right, bottom;
      logic [DEPTH_BITS-1:0]      min_depth;
      logic [DEPTH_BITS-1:0]      kept[$];
      bit                         dropped;
      near_result_type            pending[$];
      int                         mismatches, frames, found_frames, ovf_frames;

      function new();
         left      = '0;
         top       = '0;
         right     = '0;
         bottom    = '0;
         min_depth = MIN_DEPTH_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx,
                              logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_BOX_LEFT:   left      = data[BOX_BITS-1:0];
            REG_BOX_TOP:    top       = data[BOX_BITS-1:0];
            REG_BOX_RIGHT:  right     = data[BOX_BITS-1:0];
            REG_BOX_BOTTOM: bottom    = data[BOX_BITS-1:0];
            REG_MIN_DEPTH:  min_depth = data[DEPTH_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [DEPTH_BITS-1:0] depth, logic [COORD_BITS-1:0] col,
                               logic [COORD_BITS-1:0] row, logic last);
         int              c, r, n, k;
         bit              in_box;
         near_result_type res;
         c = col;
         r = row;
         in_box = c >= int'(left) && c < int'(right) && r >= int'(top) && r < int'(bottom);
         if (in_box && depth > min_depth) begin
            if (kept.size() < MAX_SAMPLES) kept.insert(kept.size(), depth);
            else dropped = 1'b1;
         end
         if (!last) return;
         n = kept.size();
         k = n / 5;
         res.found         = n > 0;
         res.overflowed    = dropped;
         res.depth_half_mm = '0;
         if (n > 0) begin
            kept.sort();
            if (k == 0)
               res.depth_half_mm = {kept[0], 1'b0};
            else if (k % 2 == 1)
               res.depth_half_mm = {kept[k/2], 1'b0};
            else
               res.depth_half_mm = RES_BITS'(kept[k/2-1]) + RES_BITS'(kept[k/2]);
         end
         pending.insert(pending.size(), res);
         frames++;
         if (res.found) found_frames++;
         if (res.overflowed) ovf_frames++;
         kept.delete();
         dropped = 1'b0;
      endfunction

      function void check_result(logic [RES_BITS-1:0] depth_half_mm, logic found,
                                 logic overflowed);
         near_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing expected: depth %0d found %b ovf %b",
                        $time, depth_half_mm, found, overflowed);
            return;
         end
         want = pending.pop_front();
         if (depth_half_mm !== want.depth_half_mm || found !== want.found ||
             overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: depth %0d/%0d found %b/%b ovf %b/%b (exp/act)",
                        $time, want.depth_half_mm, depth_half_mm, want.found, found,
                        want.overflowed, overflowed);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [DEPTH_BITS-1:0]    req_depth_mm = '0;
   logic [COORD_BITS-1:0]    req_pixel_col = '0;
   logic [COORD_BITS-1:0]    req_pixel_row = '0;
   logic                     req_frame_last = 1'b0;
   logic                     rsp_valid;
   logic [RES_BITS-1:0]      rsp_depth_half_mm;
   logic                     rsp_found;
   logic                     rsp_overflowed;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   depth_scoreboard sb;
   bit              no_idle;
   int              pixels, settings, reg_writes;

   box_near_depth_select_core dut (.*);

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_depth_half_mm, rsp_found, rsp_overflowed);
   end

   task automatic send_pixel(logic [DEPTH_BITS-1:0] depth, logic [COORD_BITS-1:0] col,
                             logic [COORD_BITS-1:0] row, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_depth_mm   <= depth;
      req_pixel_col  <= col;
      req_pixel_row  <= row;
      req_frame_last <= last;
      do @(posedge clock); while (busy);
      sb.note_pixel(depth, col, row, last);
      pixels++;
   endtask

   // wait for every predicted result, then let the selector wind down
   task automatic settle();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      reg_writes++;
   endtask

   // box limit in the low bits, junk above
   function automatic logic [CSR_DATA_BITS-1:0] box_word(int v);
      logic [CSR_DATA_BITS-1:0] w;
      w = CSR_DATA_BITS'($urandom);
      w[BOX_BITS-1:0] = v[BOX_BITS-1:0];
      return w;
   endfunction

   task automatic program_box(int l, int t, int r, int b, int m);
      settle();
      csr_write(REG_BOX_LEFT, box_word(l));
      csr_write(REG_BOX_TOP, box_word(t));
      csr_write(REG_BOX_RIGHT, box_word(r));
      csr_write(REG_BOX_BOTTOM, box_word(b));
      csr_write(REG_MIN_DEPTH, CSR_DATA_BITS'(m));
      csr_valid <= 1'b0;
      settings++;
   endtask

   // mostly inside the box, some on its edges, the rest anywhere
   function automatic logic [COORD_BITS-1:0] pick_coord(int lo, int hi);
      int a, b, roll;
      a = (lo < 0) ? 0 : lo;
      b = (hi > 4096) ? 4095 : hi - 1;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return COORD_BITS'(($urandom_range(0, 1) != 0) ? lo - 1 + int'($urandom_range(0, 1))
                                                        : hi - 1 + int'($urandom_range(0, 1)));
      if (roll < 8 && a <= b) return COORD_BITS'($urandom_range(b, a));
      return COORD_BITS'($urandom);
   endfunction

   function automatic logic [DEPTH_BITS-1:0] pick_depth(logic [DEPTH_BITS-1:0] min_mm);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return min_mm + DEPTH_BITS'($urandom_range(0, 1));
         3, 4:    return DEPTH_BITS'(1000 + $urandom_range(0, 3)); // repeated values
         default: return DEPTH_BITS'($urandom);
      endcase
   endfunction

   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("FAIL box_near_depth_select_core");
      $finish;
   end

   initial begin
      int i, len, phase, phase_items, rand_items, l, t, r, b, m;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset box is empty: nothing kept
      no_idle = 1'b0;
      send_pixel(16'd500, 12'd0, 12'd0, 1'b1);

      program_box(-4096, -4096, 4095, 4095, 0);
      send_pixel(16'd0, 12'd0, 12'd0, 1'b0);
      send_pixel(16'hffff, 12'd4095, 12'd4095, 1'b0);
      send_pixel(16'hffff, 12'd4094, 12'd4094, 1'b0);
      send_pixel(16'd1, 12'd0, 12'd4094, 1'b1);
      send_pixel(16'hffff, 12'd100, 12'd100, 1'b1);
      for (i = 0; i < 10; i++)
         send_pixel(DEPTH_BITS'($urandom_range(1, 65535)), COORD_BITS'($urandom_range(0, 4094)),
                    COORD_BITS'($urandom_range(0, 4094)), i == 9);
      no_idle = 1'b1;
      for (i = 0; i < 5; i++)
         send_pixel(DEPTH_BITS'($urandom_range(1, 65535)), COORD_BITS'(i), 12'd7, i == 4);
      program_box(-4096, -4096, 4095, 4095, 65535);
      send_pixel(16'hffff, 12'd5, 12'd5, 1'b1);

      rand_items = 0;
      phase = 0;
      while (rand_items < RAND_ITEMS) begin
         l = $urandom_range(0, 3500);
         r = l + $urandom_range(1, 595);
         t = $urandom_range(0, 3500);
         b = t + $urandom_range(1, 595);
         m = $urandom_range(0, 300);
         case (phase % 8)
            0: begin
               l = -4096; t = -4096; r = 4095; b = 4095; m = 0;
            end
            1: m = $urandom_range(0, 2000);
            2: begin // columns inverted
               l = $urandom_range(200, 4000);
               r = l - $urandom_range(1, 200);
               m = 100;
            end
            3: m = 65535;
            4: begin
               l = -4096;
               t = -int'($urandom_range(1, 4096));
               r = $urandom_range(0, 300);
               b = $urandom_range(0, 300);
               m = $urandom_range(0, 1000);
            end
            5: begin
               r = l;
               m = 0;
            end
            default: ;
         endcase
         program_box(l, t, r, b, m);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && rand_items < RAND_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 40);
            no_idle = ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++)
               send_pixel(pick_depth(sb.min_depth), pick_coord(sb.left, sb.right),
                          pick_coord(sb.top, sb.bottom), i == len - 1);
            phase_items += len;
            rand_items += len;
            if ($urandom_range(0, 7) == 0) settle();
         end
         phase++;
      end

      // one last short frame with idle gaps
      no_idle = 1'b0;
      for (i = 0; i < 7; i++)
         send_pixel(pick_depth(sb.min_depth), pick_coord(sb.left, sb.right),
                    pick_coord(sb.top, sb.bottom), i == 6);

      settle();
      repeat (20) @(posedge clock);
      $display("Ran %0d pixels in %0d frames: %0d with kept samples, %0d overflowed.",
               pixels, sb.frames, sb.found_frames, sb.ovf_frames);
      $display("Box settings %0d, register writes %0d, mismatches %0d.",
               settings, reg_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("PASS box_near_depth_select_core");
      else
         $display("FAIL box_near_depth_select_core");
      $finish;
   end

endmodule
